// ===== rtl/abcc_pkg.sv =====
// types, constants and helpers shared by the countdown controller
package abcc_pkg;

  typedef enum logic [1:0] {
    MODE_SETTING = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  localparam logic [3:0] DIGIT_MAX    = 4'd9;
  localparam logic [2:0] SEC_TENS_MAX = 3'd5;
  localparam logic [4:0] DIGIT_BASE   = 5'd10;

  localparam logic [9:0] WATTS_800 = 10'd800;
  localparam logic [9:0] WATTS_600 = 10'd600;
  localparam logic [9:0] WATTS_350 = 10'd350;
  localparam logic [9:0] WATTS_200 = 10'd200;

  typedef struct packed {
    logic start_pause;
    logic reset_press;
    logic power_step;
    logic add_minute;
    logic add_ten_seconds;
  } buttons_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] power_level;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
  } ctrl_state_t;

  function automatic logic [9:0] watts_of(input logic [1:0] level);
    logic [9:0] w;
    case (level)
      2'd0:    w = WATTS_800;
      2'd1:    w = WATTS_600;
      2'd2:    w = WATTS_350;
      2'd3:    w = WATTS_200;
      default: w = WATTS_800;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/abcc_ifs.sv =====
// request and result channel interfaces of the countdown controller

interface abcc_req_if;
  logic valid;
  logic ready;
  logic start_pause;
  logic reset_press;
  logic power_step;
  logic add_minute;
  logic add_ten_seconds;

  modport source (output valid, start_pause, reset_press, power_step, add_minute,
                  add_ten_seconds, input ready);
  modport sink (input valid, start_pause, reset_press, power_step, add_minute,
                add_ten_seconds, output ready);
endinterface

interface abcc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] power_level;
  logic [9:0] power_watts;
  logic [3:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;

  modport source (output valid, mode, power_level, power_watts, minute_tens, minute_ones,
                  second_tens, second_ones, input ready);
  modport sink (input valid, mode, power_level, power_watts, minute_tens, minute_ones,
                second_tens, second_ones, output ready);
endinterface

// ===== rtl/abcc_step.sv =====
// next-state logic for one control pass: mode, power level and bcd time
module abcc_step (
  input  abcc_pkg::ctrl_state_t cur,
  input  abcc_pkg::buttons_t    btn,
  output abcc_pkg::ctrl_state_t nxt
);
  import abcc_pkg::*;

  always_comb begin
    mode_t       m;
    ctrl_state_t s;
    logic        time_zero;
    logic        sec_wrap;
    logic [1:0]  min_inc;
    logic [4:0]  mo_sum;
    logic        mo_carry;
    logic [3:0]  mt_sum;
    logic [2:0]  st_new;

    m = cur.mode;
    if (btn.start_pause) begin
      m = (m == MODE_RUNNING) ? MODE_PAUSED : MODE_RUNNING;
    end

    s = cur;
    if (btn.reset_press) begin
      m = MODE_SETTING;
      s.power_level = 2'd0;
      s.minute_tens = 4'd0;
      s.minute_ones = 4'd0;
      s.second_tens = 3'd0;
      s.second_ones = 4'd0;
    end
    s.mode = m;

    time_zero = (s.minute_tens == 4'd0) && (s.minute_ones == 4'd0) &&
                (s.second_tens == 3'd0) && (s.second_ones == 4'd0);

    // ten-second add wraps into the minutes
    sec_wrap = btn.add_ten_seconds && (s.second_tens == SEC_TENS_MAX);
    min_inc  = {1'b0, btn.add_minute} + {1'b0, sec_wrap};
    mo_sum   = {1'b0, s.minute_ones} + {3'b000, min_inc};
    mo_carry = (mo_sum >= DIGIT_BASE);
    mt_sum   = s.minute_tens + {3'b000, mo_carry};
    if (!btn.add_ten_seconds) begin
      st_new = s.second_tens;
    end else if (sec_wrap) begin
      st_new = 3'd0;
    end else begin
      st_new = s.second_tens + 3'd1;
    end

    nxt = s;
    case (m)
      MODE_RUNNING: begin
        if (time_zero) begin
          nxt.mode = MODE_DONE;
        end else if (s.second_ones != 4'd0) begin
          nxt.second_ones = s.second_ones - 4'd1;
        end else begin
          nxt.second_ones = DIGIT_MAX;
          if (s.second_tens != 3'd0) begin
            nxt.second_tens = s.second_tens - 3'd1;
          end else begin
            nxt.second_tens = SEC_TENS_MAX;
            if (s.minute_ones != 4'd0) begin
              nxt.minute_ones = s.minute_ones - 4'd1;
            end else begin
              nxt.minute_ones = DIGIT_MAX;
              nxt.minute_tens = s.minute_tens - 4'd1;
            end
          end
        end
      end
      MODE_SETTING: begin
        if (btn.power_step) begin
          nxt.power_level = s.power_level + 2'd1;
        end
        if (mt_sum == DIGIT_BASE[3:0]) begin
          // past 99:59, hold at the limit
          nxt.minute_tens = DIGIT_MAX;
          nxt.minute_ones = DIGIT_MAX;
          nxt.second_tens = SEC_TENS_MAX;
          nxt.second_ones = DIGIT_MAX;
        end else begin
          nxt.minute_tens = mt_sum;
          nxt.minute_ones = mo_carry ? 4'(mo_sum - DIGIT_BASE) : mo_sum[3:0];
          nxt.second_tens = st_new;
        end
      end
      default: begin
        nxt = s;
      end
    endcase
  end

endmodule

// ===== rtl/appliance_bcd_countdown_controller.sv =====
// top level: request register, control pass logic, state and result registers
// Takes one request (one control pass) per clock and returns one result per request,
// the mode, power and mm:ss time after that pass. A request is held in the request
// register; when it advances, the pass logic updates the state and the result register
// together, so the next request sees the updated state without a gap. While a result
// waits, one more request can be taken into the request register; after that the input
// stalls until the result is taken. Throughput is one request per cycle as long as
// results are taken.
module appliance_bcd_countdown_controller (
  input logic         clk,
  input logic         rst,
  abcc_req_if.sink    cmd,
  abcc_res_if.source  status
);
  import abcc_pkg::*;

  logic        req_valid;
  buttons_t    req_btn;
  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        res_valid;
  ctrl_state_t res;
  logic        advance;

  assign advance   = req_valid && (!res_valid || status.ready);
  assign cmd.ready = !req_valid || advance;

  abcc_step u_step (
    .cur (state),
    .btn (req_btn),
    .nxt (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (cmd.ready) begin
      req_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      req_btn.start_pause     <= cmd.start_pause;
      req_btn.reset_press     <= cmd.reset_press;
      req_btn.power_step      <= cmd.power_step;
      req_btn.add_minute      <= cmd.add_minute;
      req_btn.add_ten_seconds <= cmd.add_ten_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= MODE_SETTING;
      state.power_level <= 2'd0;
      state.minute_tens <= 4'd0;
      state.minute_ones <= 4'd0;
      state.second_tens <= 3'd0;
      state.second_ones <= 4'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (status.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= state_next;
    end
  end

  assign status.valid       = res_valid;
  assign status.mode        = res.mode;
  assign status.power_level = res.power_level;
  assign status.power_watts = watts_of(res.power_level);
  assign status.minute_tens = res.minute_tens;
  assign status.minute_ones = res.minute_ones;
  assign status.second_tens = res.second_tens;
  assign status.second_ones = res.second_ones;

endmodule
